### design/sseg_pkg.sv
// Shared types and constants for the four-digit seven-segment display image.
// Command and result payloads, pipeline records and the hex glyph table.
// No dependencies.
package sseg_pkg;

  typedef enum logic [2:0] {
    OP_SET_BITS   = 3'd0,
    OP_CLEAR_BITS = 3'd1,
    OP_SET_BYTE   = 3'd2,
    OP_HEX_BYTE   = 3'd3,
    OP_HEX_WORD   = 3'd4,
    OP_DECIMAL    = 3'd5,
    OP_CLEAR_ALL  = 3'd6
  } op_t;

  localparam int NUM_DIGITS = 4;
  localparam int MAG_W      = 14;
  localparam int LEVEL_W    = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = LEVEL_W;

  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_LEVEL = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SEG_TEST    = 1'b1;

  localparam logic [LEVEL_W-1:0] LEVEL_RESET = 3'd4;
  localparam logic [7:0]         SEG_MINUS   = 8'h40;
  localparam logic [7:0]         SEG_BLANK   = 8'h00;
  localparam logic [2:0]         CTRL_LOW    = 3'b111;

  typedef struct packed {
    op_t         action;
    logic [1:0]  digit_index;
    logic [7:0]  mask_byte;
    logic [15:0] value;
    logic        upper_half;
    logic        zero_pad;
  } cmd_t;

  typedef struct packed {
    logic [7:0] control_word;
    logic [7:0] segments_digit0;
    logic [7:0] segments_digit1;
    logic [7:0] segments_digit2;
    logic [7:0] segments_digit3;
  } res_t;

  typedef struct packed {
    op_t              action;
    logic [1:0]       digit_index;
    logic [7:0]       mask_byte;
    logic [15:0]      value;
    logic             upper_half;
    logic             zero_pad;
    logic             neg;
    logic             bad;
    logic [MAG_W-1:0] mag;
  } prep_t;

  typedef struct packed {
    logic [NUM_DIGITS-1:0][7:0] keep;
    logic [NUM_DIGITS-1:0][7:0] set;
  } form_t;

  function automatic logic [7:0] hex_glyph(input logic [3:0] nib);
    logic [7:0] g;
    case (nib)
      4'h0: g = 8'h3F;
      4'h1: g = 8'h06;
      4'h2: g = 8'h5B;
      4'h3: g = 8'h4F;
      4'h4: g = 8'h66;
      4'h5: g = 8'h6D;
      4'h6: g = 8'h7D;
      4'h7: g = 8'h07;
      4'h8: g = 8'h7F;
      4'h9: g = 8'h6F;
      4'hA: g = 8'h5F;
      4'hB: g = 8'h7C;
      4'hC: g = 8'h58;
      4'hD: g = 8'h5E;
      4'hE: g = 8'h79;
      default: g = 8'h71;
    endcase
    return g;
  endfunction

endpackage

### design/sseg_prep.sv
// First pipeline stage: sign, magnitude and range check of the decimal value.
// Depends on sseg_pkg.
module sseg_prep import sseg_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  load,
  input  logic  in_valid,
  input  cmd_t  cmd,
  output logic  valid,
  output prep_t prep
);

  logic signed [15:0] sval;
  logic [15:0]        mag_full;
  prep_t              prep_next;

  always_comb begin
    sval     = signed'(cmd.value);
    mag_full = cmd.value[15] ? (~cmd.value + 16'd1) : cmd.value;
    prep_next.action      = cmd.action;
    prep_next.digit_index = cmd.digit_index;
    prep_next.mask_byte   = cmd.mask_byte;
    prep_next.value       = cmd.value;
    prep_next.upper_half  = cmd.upper_half;
    prep_next.zero_pad    = cmd.zero_pad;
    prep_next.neg         = cmd.value[15];
    prep_next.bad         = (sval > 16'sd9999) || (sval < -16'sd999);
    prep_next.mag         = mag_full[MAG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      prep <= prep_next;
    end
  end

endmodule

### design/sseg_form.sv
// Second pipeline stage: decimal digit split and glyph lookup, giving a
// keep mask and a set pattern per digit for the image update. Depends on sseg_pkg.
module sseg_form import sseg_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  load,
  input  logic  in_valid,
  input  prep_t prep,
  output logic  valid,
  output form_t form
);

  localparam logic [29:0] RECIP_10   = 30'd52429;
  localparam logic [29:0] RECIP_100  = 30'd5243;
  localparam logic [29:0] RECIP_1000 = 30'd8389;

  logic [29:0]                p10, p100, p1000;
  logic [9:0]                 q10;
  logic [6:0]                 q100;
  logic [3:0]                 q1000;
  logic [MAG_W-1:0]           d0_full;
  logic [9:0]                 d1_full;
  logic [6:0]                 d2_full;
  logic [NUM_DIGITS-1:0][3:0] d;
  logic [1:0]                 top;
  logic [1:0]                 minus_idx;
  logic [NUM_DIGITS-1:0][7:0] dec_img;
  form_t                      form_next;

  // constant reciprocals, exact for magnitudes up to 9999
  always_comb begin
    p10     = 30'(prep.mag) * RECIP_10;
    p100    = 30'(prep.mag) * RECIP_100;
    p1000   = 30'(prep.mag) * RECIP_1000;
    q10     = p10[28:19];
    q100    = p100[25:19];
    q1000   = p1000[26:23];
    d0_full = prep.mag - 14'({q10, 3'b000}) - 14'({q10, 1'b0});
    d1_full = q10 - 10'({q100, 3'b000}) - 10'({q100, 1'b0});
    d2_full = q100 - 7'({q1000, 3'b000}) - 7'({q1000, 1'b0});
    d[0]    = d0_full[3:0];
    d[1]    = d1_full[3:0];
    d[2]    = d2_full[3:0];
    d[3]    = q1000;
  end

  always_comb begin
    if (d[3] != 4'd0) begin
      top = 2'd3;
    end else if (d[2] != 4'd0) begin
      top = 2'd2;
    end else if (d[1] != 4'd0) begin
      top = 2'd1;
    end else begin
      top = 2'd0;
    end
    minus_idx = top + 2'd1;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (prep.bad) begin
        dec_img[i] = SEG_MINUS;
      end else if (prep.zero_pad || (2'(i) <= top)) begin
        dec_img[i] = hex_glyph(d[i]);
      end else begin
        dec_img[i] = SEG_BLANK;
      end
    end
    if (!prep.bad && prep.neg) begin
      if (prep.zero_pad) begin
        dec_img[3] = SEG_MINUS;
      end else begin
        dec_img[minus_idx] = SEG_MINUS;
      end
    end
  end

  always_comb begin
    form_next.keep = '1;
    form_next.set  = '0;
    case (prep.action)
      OP_SET_BITS: begin
        form_next.set[prep.digit_index] = prep.mask_byte;
      end
      OP_CLEAR_BITS: begin
        form_next.keep[prep.digit_index] = ~prep.mask_byte;
      end
      OP_SET_BYTE: begin
        form_next.keep[prep.digit_index] = 8'h00;
        form_next.set[prep.digit_index]  = prep.mask_byte;
      end
      OP_HEX_BYTE: begin
        if (prep.upper_half) begin
          form_next.keep[2] = 8'h00;
          form_next.keep[3] = 8'h00;
          form_next.set[2]  = hex_glyph(prep.value[3:0]);
          form_next.set[3]  = hex_glyph(prep.value[7:4]);
        end else begin
          form_next.keep[0] = 8'h00;
          form_next.keep[1] = 8'h00;
          form_next.set[0]  = hex_glyph(prep.value[3:0]);
          form_next.set[1]  = hex_glyph(prep.value[7:4]);
        end
      end
      OP_HEX_WORD: begin
        form_next.keep = '0;
        for (int i = 0; i < NUM_DIGITS; i++) begin
          form_next.set[i] = hex_glyph(prep.value[4*i +: 4]);
        end
      end
      OP_DECIMAL: begin
        form_next.keep = '0;
        form_next.set  = dec_img;
      end
      OP_CLEAR_ALL: begin
        form_next.keep = '0;
      end
      default: begin
        form_next.keep = '1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      form <= form_next;
    end
  end

endmodule

### design/seven_segment_display_image.sv
// Four-digit seven-segment display image: one command in, one result out; a
// command passes the input register, value prep, glyph forming and the result
// register in that order; one command per cycle sustained while the result side
// does not stall; every stage moves on independently when
// the one below is free. The image itself is the result register, updated by
// a mask-and-set merge in the last stage, so each command sees the image left
// by the one before it. Depends on sseg_pkg, sseg_prep, sseg_form.
module seven_segment_display_image import sseg_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  write_enable,
  input  logic [CFG_IDX_W-1:0]  write_index,
  input  logic [CFG_DATA_W-1:0] write_data,
  input  logic                  cmd_valid,
  output logic                  cmd_stall,
  input  cmd_t                  cmd,
  output logic                  res_valid,
  input  logic                  res_stall,
  output res_t                  res
);

  logic [LEVEL_W-1:0]         drive_current_level;
  logic                       segment_test_on;
  logic                       s0_valid;
  cmd_t                       s0_cmd;
  logic                       s1_valid;
  prep_t                      s1_prep;
  logic                       s2_valid;
  form_t                      s2_form;
  logic                       ready0, ready1, ready2, ready3;
  logic                       res_load;
  logic [NUM_DIGITS-1:0][7:0] image;
  logic [NUM_DIGITS-1:0][7:0] image_next;
  logic [7:0]                 control_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      drive_current_level <= LEVEL_RESET;
      segment_test_on     <= 1'b0;
    end else if (write_enable) begin
      case (write_index)
        REG_DRIVE_LEVEL: drive_current_level <= write_data[LEVEL_W-1:0];
        REG_SEG_TEST:    segment_test_on     <= write_data[0];
        default:         segment_test_on     <= segment_test_on;
      endcase
    end
  end

  assign ready3    = !res_valid || !res_stall;
  assign ready2    = !s2_valid || ready3;
  assign ready1    = !s1_valid || ready2;
  assign ready0    = !s0_valid || ready1;
  assign cmd_stall = !ready0;
  assign res_load  = ready3 && s2_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (ready0) begin
      s0_valid <= cmd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready0) begin
      s0_cmd <= cmd;
    end
  end

  sseg_prep u_prep (
    .clk      (clk),
    .rst      (rst),
    .load     (ready1),
    .in_valid (s0_valid),
    .cmd      (s0_cmd),
    .valid    (s1_valid),
    .prep     (s1_prep)
  );

  sseg_form u_form (
    .clk      (clk),
    .rst      (rst),
    .load     (ready2),
    .in_valid (s1_valid),
    .prep     (s1_prep),
    .valid    (s2_valid),
    .form     (s2_form)
  );

  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      image_next[i] = (image[i] & s2_form.keep[i]) | s2_form.set[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      image     <= '0;
    end else if (ready3) begin
      res_valid <= s2_valid;
      if (s2_valid) begin
        image <= image_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      control_word <= {1'b0, drive_current_level, segment_test_on, CTRL_LOW};
    end
  end

  always_comb begin
    res.control_word    = control_word;
    res.segments_digit0 = image[0];
    res.segments_digit1 = image[1];
    res.segments_digit2 = image[2];
    res.segments_digit3 = image[3];
  end

`ifndef SYNTHESIS
  a_image_only_on_load: assert property (@(posedge clk) disable iff (rst)
    !res_load |=> $stable(image))
    else $error("image changed without a result transfer");

  a_empty_input_no_stall: assert property (@(posedge clk) disable iff (rst)
    !s0_valid |-> !cmd_stall)
    else $error("input stalled with empty input register");

  a_stage2_held: assert property (@(posedge clk) disable iff (rst)
    (s2_valid && !ready3) |=> s2_valid)
    else $error("stage 2 item lost while blocked");

  a_result_follows_stage2: assert property (@(posedge clk) disable iff (rst)
    res_load |=> res_valid)
    else $error("result not presented after stage 2 transfer");
`endif

endmodule
